@@ sv/kic_pkg.sv @@
// Shared types and constants for the circular keyframe interpolator.
`timescale 1ns / 1ps
package kic_pkg;

	localparam int FRAC_BITS    = 16;
	localparam int DEF_MAX_KEYS = 256;
	localparam int DEF_MAX_VARS = 16;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_KEYS_IN_USE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_VARS_IN_USE = 2'd1;

	localparam logic [1:0] KIND_DESC  = 2'd0;
	localparam logic [1:0] KIND_TIME  = 2'd1;
	localparam logic [1:0] KIND_VALUE = 2'd2;
	localparam logic [1:0] KIND_QUERY = 2'd3;

	typedef struct packed {
		logic [1:0]         kind;
		logic [7:0]         key_index;
		logic [3:0]         var_index;
		logic [31:0]        time_value;
		logic signed [31:0] sample_value;
		logic               is_circular;
		logic [30:0]        range_width;
	} in_item_t;

	typedef struct packed {
		logic [3:0]         out_var;
		logic signed [31:0] out_value;
		logic               last;
	} out_item_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic wr;
		logic capture;
		logic t0_ld;
		logic walk;
		logic t1_ld;
		logic div_init;
		logic div_step;
		logic v_rd0;
		logic v_rd1;
		logic wrap;
		logic mul;
		logic emit;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic adv;
		logic u_fixed;
		logic div_done;
		logic last_var;
		logic out_free;
	} status_t;

endpackage

@@ sv/kic_ctrl.sv @@
// Controller state machine for the circular keyframe interpolator.
`timescale 1ns / 1ps
module kic_ctrl
	import kic_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	input  logic [1:0] in_kind,
	output logic     in_ready,
	input  status_t  sts,
	output cmd_t     cmd
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_T0   = 3'd1;
	localparam logic [2:0] S_CMP  = 3'd2;
	localparam logic [2:0] S_DSET = 3'd3;
	localparam logic [2:0] S_DIV  = 3'd4;
	localparam logic [2:0] S_V0   = 3'd5;
	localparam logic [2:0] S_V1   = 3'd6;
	localparam logic [2:0] S_WRAP = 3'd7;

	logic [2:0] state_q, state_d;
	logic       mul_q, mul_d;
	logic       out_q, out_d;
	logic       acc;

	assign in_ready = (state_q == S_IDLE) && !mul_q && !out_q;
	assign acc      = in_valid && in_ready;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		mul_d   = 1'b0;
		out_d   = out_q;
		if (mul_q) begin
			cmd.mul = 1'b1;
			out_d   = 1'b1;
		end else if (out_q) begin
			// The result waits here until the output register is free.
			if (sts.out_free) begin
				cmd.emit = 1'b1;
				out_d    = 1'b0;
				state_d  = sts.last_var ? S_IDLE : S_V0;
			end
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (acc) begin
						if (in_kind == KIND_QUERY) begin
							cmd.capture = 1'b1;
							state_d     = S_T0;
						end else begin
							cmd.wr = 1'b1;
						end
					end
				end
				S_T0: begin
					cmd.t0_ld = 1'b1;
					state_d   = S_CMP;
				end
				S_CMP: begin
					if (sts.adv) begin
						cmd.walk = 1'b1;
					end else begin
						cmd.t1_ld = 1'b1;
						state_d   = S_DSET;
					end
				end
				S_DSET: begin
					cmd.div_init = 1'b1;
					state_d      = sts.u_fixed ? S_V0 : S_DIV;
				end
				S_DIV: begin
					cmd.div_step = 1'b1;
					if (sts.div_done) begin
						state_d = S_V0;
					end
				end
				S_V0: begin
					cmd.v_rd0 = 1'b1;
					state_d   = S_V1;
				end
				S_V1: begin
					cmd.v_rd1 = 1'b1;
					state_d   = S_WRAP;
				end
				S_WRAP: begin
					cmd.wrap = 1'b1;
					mul_d    = 1'b1;
				end
				default: state_d = S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			mul_q   <= 1'b0;
			out_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			mul_q   <= mul_d;
			out_q   <= out_d;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> sts.out_free)
		else $error("result emitted while output register is occupied");
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.wrap |=> cmd.mul)
		else $error("multiply step did not follow wrap step");
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.capture |=> state_q == S_T0)
		else $error("query capture did not start the key walk");

endmodule

@@ sv/kic_dp.sv @@
// Datapath: tables, key walk, fraction divider and blend arithmetic.
`timescale 1ns / 1ps
module kic_dp
	import kic_pkg::*;
#(
	parameter int MAX_KEYS = DEF_MAX_KEYS,
	parameter int MAX_VARS = DEF_MAX_VARS
)(
	input  logic                  clk,
	input  logic                  arst_n,
	input  cmd_t                  cmd,
	output status_t               sts,
	input  in_item_t              in_data,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output logic                  out_valid,
	input  logic                  out_ready,
	output out_item_t             out_data
);

	localparam int KW = $clog2(MAX_KEYS);
	localparam int VW = (MAX_VARS > 1) ? $clog2(MAX_VARS) : 1;
	localparam int AW = $clog2(MAX_KEYS * MAX_VARS);
	localparam int CW = (FRAC_BITS > 1) ? $clog2(FRAC_BITS) : 1;
	localparam logic [FRAC_BITS:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

	logic [31:0]        key_times [MAX_KEYS];
	logic signed [31:0] key_values [MAX_KEYS * MAX_VARS];
	logic               circ_flags [MAX_VARS];
	logic [30:0]        range_w [MAX_VARS];

	logic [8:0]  keys_q;
	logic [4:0]  vars_q;
	logic [31:0] tv_q, t0_q, t1_q, trd_q;
	logic [KW-1:0] k_q, lim_q;
	logic [VW-1:0] i_q, ilast_q;
	logic [FRAC_BITS:0] u_q;
	logic [31:0] rem_q;
	logic [FRAC_BITS-1:0] quo_q;
	logic [CW-1:0] cnt_q;
	logic signed [31:0] vrd_q, v0_q;
	logic signed [33:0] v1a_q;
	logic signed [49:0] p0_s1;
	logic signed [51:0] p1_s1;
	logic        out_valid_q;
	out_item_t   out_q;

	logic [KW-1:0] taddr;
	logic [AW-1:0] vaddr, waddr;
	logic [31:0]   num, den;
	logic [32:0]   r2;
	logic          bit_q;
	logic [31:0]   rem_n;
	logic [FRAC_BITS-1:0] quo_n;
	logic signed [32:0] diff;
	logic [32:0]   dabs;
	logic [35:0]   d5;
	logic [35:0]   r4;
	logic signed [33:0] v1s, v1adj;
	logic signed [52:0] acc_sum;
	int            nk, nv;

	always_comb begin
		nk = int'(keys_q);
		if (nk < 2) nk = 2;
		if (nk > MAX_KEYS) nk = MAX_KEYS;
		nv = int'(vars_q);
		if (nv < 1) nv = 1;
		if (nv > MAX_VARS) nv = MAX_VARS;
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			keys_q <= 9'd2;
			vars_q <= 5'd1;
		end else if (cfg_we) begin
			if (cfg_index == REG_KEYS_IN_USE) keys_q <= cfg_data[8:0];
			if (cfg_index == REG_VARS_IN_USE) vars_q <= cfg_data[4:0];
		end
	end

	// Key time table: one port, registered read.
	always_comb begin
		if (cmd.capture) taddr = '0;
		else if (cmd.walk) taddr = k_q + KW'(2);
		else taddr = k_q + KW'(1);
	end

	always_ff @(posedge clk) begin
		if (cmd.wr && in_data.kind == KIND_TIME && int'(in_data.key_index) < MAX_KEYS)
			key_times[KW'(in_data.key_index)] <= in_data.time_value;
		trd_q <= key_times[taddr];
	end

	// Key value table: one port, registered read.
	assign vaddr = cmd.v_rd0 ? AW'(int'(k_q) * MAX_VARS + int'(i_q))
	                         : AW'((int'(k_q) + 1) * MAX_VARS + int'(i_q));
	assign waddr = AW'(int'(in_data.key_index) * MAX_VARS + int'(in_data.var_index));

	always_ff @(posedge clk) begin
		if (cmd.wr && in_data.kind == KIND_VALUE && int'(in_data.key_index) < MAX_KEYS
		    && int'(in_data.var_index) < MAX_VARS)
			key_values[waddr] <= in_data.sample_value;
		vrd_q <= key_values[vaddr];
	end

	always_ff @(posedge clk) begin
		if (cmd.wr && in_data.kind == KIND_DESC && int'(in_data.var_index) < MAX_VARS) begin
			circ_flags[VW'(in_data.var_index)] <= in_data.is_circular;
			range_w[VW'(in_data.var_index)]    <= in_data.range_width;
		end
	end

	// Fraction: restoring division, one quotient bit per cycle.
	assign num   = (tv_q > t0_q) ? (tv_q - t0_q) : 32'd0;
	assign den   = t1_q - t0_q;
	assign r2    = {rem_q, 1'b0};
	assign bit_q = (r2 >= {1'b0, den});
	assign rem_n = bit_q ? 32'(r2 - {1'b0, den}) : r2[31:0];
	assign quo_n = {quo_q[FRAC_BITS-2:0], bit_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q   <= '0;
			lim_q <= '0;
			u_q   <= '0;
			i_q   <= '0;
		end else begin
			if (cmd.capture) begin
				k_q   <= '0;
				lim_q <= KW'(nk - 2);
			end else if (cmd.walk) begin
				k_q <= k_q + KW'(1);
			end
			if (cmd.div_init) begin
				i_q <= '0;
				if (t1_q == t0_q) u_q <= ONE;
				else if (t1_q < t0_q) u_q <= '0;
				else if (num >= den) u_q <= ONE;
			end else if (cmd.div_step && sts.div_done) begin
				u_q <= {1'b0, quo_n};
			end
			if (cmd.emit && !sts.last_var) i_q <= i_q + VW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			tv_q    <= in_data.time_value;
			ilast_q <= VW'(nv - 1);
		end
		if (cmd.t0_ld || cmd.walk) t0_q <= trd_q;
		if (cmd.t1_ld) t1_q <= trd_q;
		if (cmd.div_init) begin
			rem_q <= num;
			quo_q <= '0;
			cnt_q <= '0;
		end else if (cmd.div_step) begin
			rem_q <= rem_n;
			quo_q <= quo_n;
			cnt_q <= cnt_q + CW'(1);
		end
	end

	// Circular correction: move v1 one range toward v0 when 5*|d| > 4*range.
	assign v1s   = 34'(vrd_q);
	assign diff  = 33'(v0_q) - 33'(vrd_q);
	assign dabs  = diff[32] ? 33'(-diff) : 33'(diff);
	assign d5    = 36'(dabs) * 36'd5;
	assign r4    = {3'b0, range_w[i_q], 2'b00};
	always_comb begin
		v1adj = v1s;
		if (circ_flags[i_q] && d5 > r4) begin
			if (v0_q < vrd_q) v1adj = v1s - 34'($signed({1'b0, range_w[i_q]}));
			else v1adj = v1s + 34'($signed({1'b0, range_w[i_q]}));
		end
	end

	assign acc_sum = 53'(p0_s1) + 53'(p1_s1);

	always_ff @(posedge clk) begin
		if (cmd.v_rd1) v0_q <= vrd_q;
		if (cmd.wrap) v1a_q <= v1adj;
		if (cmd.mul) begin
			p0_s1 <= $signed({1'b0, ONE - u_q}) * v0_q;
			p1_s1 <= $signed({1'b0, u_q}) * v1a_q;
		end
		if (cmd.emit) begin
			out_q.out_var   <= 4'(i_q);
			out_q.out_value <= acc_sum[FRAC_BITS+31:FRAC_BITS];
			out_q.last      <= (i_q == ilast_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (cmd.emit) out_valid_q <= 1'b1;
		else if (out_ready) out_valid_q <= 1'b0;
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	assign sts.adv      = (k_q < lim_q) && (tv_q > trd_q);
	assign sts.u_fixed  = (t1_q <= t0_q) || (num >= den);
	assign sts.div_done = (cnt_q == CW'(FRAC_BITS - 1));
	assign sts.last_var = (i_q == ilast_q);
	assign sts.out_free = !out_valid_q || out_ready;

	assert property (@(posedge clk) disable iff (!arst_n) u_q <= ONE)
		else $error("fraction exceeds one");
	assert property (@(posedge clk) disable iff (!arst_n) k_q <= lim_q)
		else $error("key walk passed the final pair");
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.walk |=> k_q == $past(k_q) + KW'(1))
		else $error("key index did not advance on a walk step");

endmodule

@@ sv/keyframe_interpolator_circular_unit.sv @@
// Top level of the circular keyframe interpolator.
//
//  channel | signals                      | direction | carries
//  in      | in_valid, in_ready, in_data   | input     | table writes and query requests
//  out     | out_valid, out_ready, out_data| output    | one interpolated value per variable
//  cfg     | cfg_valid, cfg_ready, idx/data| input     | keys_in_use, vars_in_use
//
// A table write is taken while the block is idle. A query walks the keys, then loads the
// later key time and checks the fraction, then runs the divider unless the key times are
// equal or decreasing or the query is at or past the later key, then for each variable
// does two value-table reads, wrap correction, multiply and output load.
// Reset clears control state and the configuration registers; tables are not cleared.
// A stalled output holds the sequence at the output load; new requests wait until done.
`timescale 1ns / 1ps
module keyframe_interpolator_circular_unit
	import kic_pkg::*;
#(
	parameter int MAX_KEYS = DEF_MAX_KEYS,
	parameter int MAX_VARS = DEF_MAX_VARS
)(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  in_item_t              in_data,
	output logic                  out_valid,
	input  logic                  out_ready,
	output out_item_t             out_data,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	cmd_t    cmd;
	status_t sts;

	assign cfg_ready = 1'b1;

	kic_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_kind  (in_data.kind),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	kic_dp #(
		.MAX_KEYS (MAX_KEYS),
		.MAX_VARS (MAX_VARS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.in_data   (in_data),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

@@ tb/keyframe_interpolator_circular_unit_tb.sv @@
// Self-checking testbench for the circular keyframe interpolator top level.
`timescale 1ns / 1ps
module keyframe_interpolator_circular_unit_tb;
	import kic_pkg::*;

	localparam int WATCHDOG_LIMIT = 20000;
	localparam int SETTLE_CYCLES  = 40;
	localparam int PHASE_ITEMS    = 40;
	localparam int NUM_PHASES     = 6;
	localparam int FILLED_KEYS    = 8;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  in_valid = 1'b0;
	logic                  in_ready;
	in_item_t              in_data = '0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	out_item_t             out_data;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	// Shadow copy of the block state used to predict interpolated values.
	logic [8:0]         keys_reg;
	logic [4:0]         vars_reg;
	logic [31:0]        key_time_tbl [DEF_MAX_KEYS];
	logic signed [31:0] key_val_tbl  [DEF_MAX_KEYS][DEF_MAX_VARS];
	logic               circ_tbl     [DEF_MAX_VARS];
	logic [30:0]        span_tbl     [DEF_MAX_VARS];

	out_item_t pending_values[$];
	bit        failed = 0;
	int        send_idle_pct = 0;
	int        recv_idle_pct = 0;
	int        quiet_cycles = 0;

	keyframe_interpolator_circular_unit DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic int active_keys();
		if (keys_reg < 2) return 2;
		if (keys_reg > DEF_MAX_KEYS) return DEF_MAX_KEYS;
		return int'(keys_reg);
	endfunction

	function automatic int active_vars();
		if (vars_reg < 1) return 1;
		if (vars_reg > DEF_MAX_VARS) return DEF_MAX_VARS;
		return int'(vars_reg);
	endfunction

	function automatic longint unsigned blend_weight(logic [31:0] t, logic [31:0] t0,
			logic [31:0] t1);
		longint unsigned one;
		longint unsigned num;
		longint unsigned w;
		one = 64'd1 << FRAC_BITS;
		if (t1 == t0) return one;
		if (t1 < t0) return 64'd0;
		num = (t > t0) ? longint'(t - t0) : 64'd0;
		w = (num << FRAC_BITS) / longint'(t1 - t0);
		return (w > one) ? one : w;
	endfunction

	task automatic expect_result(out_item_t res);
		pending_values = {pending_values, res};
	endtask

	// Applies one request to the shadow state and queues the values a query produces.
	task automatic apply_request(in_item_t it);
		int k;
		int nk;
		int nv;
		longint unsigned w;
		longint v0;
		longint v1;
		longint d;
		longint acc;
		out_item_t res;
		case (it.kind)
			KIND_DESC: begin
				circ_tbl[it.var_index] = it.is_circular;
				span_tbl[it.var_index] = it.range_width;
			end
			KIND_TIME: key_time_tbl[it.key_index] = it.time_value;
			KIND_VALUE: key_val_tbl[it.key_index][it.var_index] = it.sample_value;
			default: begin
				nk = active_keys();
				nv = active_vars();
				k = 0;
				while (k < nk - 2 && it.time_value > key_time_tbl[k + 1]) k++;
				w = blend_weight(it.time_value, key_time_tbl[k], key_time_tbl[k + 1]);
				for (int i = 0; i < nv; i++) begin
					v0 = key_val_tbl[k][i];
					v1 = key_val_tbl[k + 1][i];
					if (circ_tbl[i]) begin
						d = (v0 > v1) ? v0 - v1 : v1 - v0;
						// Take the short way around when the jump is most of the range.
						if (5 * d > 4 * longint'(span_tbl[i])) begin
							if (v0 < v1) v1 -= longint'(span_tbl[i]);
							else v1 += longint'(span_tbl[i]);
						end
					end
					acc = ((longint'(1) << FRAC_BITS) - longint'(w)) * v0 + longint'(w) * v1;
					res.out_var = i[3:0];
					res.out_value = 32'(acc >>> FRAC_BITS);
					res.last = (i == nv - 1);
					expect_result(res);
				end
			end
		endcase
	endtask

	// Called at a rising edge; returns at the edge where the request was taken.
	task automatic send_request(in_item_t it, bit typed_chk = 0,
			logic signed [31:0] typed_value = '0);
		out_item_t res;
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= it;
		do @(posedge clk); while (!in_ready);
		if (typed_chk) begin
			res.out_var = '0;
			res.out_value = typed_value;
			res.last = 1'b1;
			expect_result(res);
		end else begin
			apply_request(it);
		end
	endtask

	task automatic go_idle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_values.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		if (idx == REG_KEYS_IN_USE) keys_reg = val[8:0];
		else if (idx == REG_VARS_IN_USE) vars_reg = val[4:0];
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	function automatic in_item_t make_item(logic [1:0] kind, logic [7:0] ki, logic [3:0] vi,
			logic [31:0] tv, logic [31:0] sv, logic circ, logic [30:0] span);
		in_item_t it;
		it.kind = kind;
		it.key_index = ki;
		it.var_index = vi;
		it.time_value = tv;
		it.sample_value = sv;
		it.is_circular = circ;
		it.range_width = span;
		return it;
	endfunction

	function automatic logic [31:0] pick_sample();
		if ($urandom_range(99) < 20) return $urandom;
		return 32'($urandom_range(32'h0100_0000)) - 32'h0080_0000;
	endfunction

	// Only the first FILLED_KEYS keys hold data; queries never walk past the last of them.
	function automatic in_item_t random_request();
		in_item_t it;
		int nk;
		int top;
		int sel;
		int ki;
		logic [31:0] lo;
		logic [31:0] hi;
		nk = active_keys();
		top = (nk < FILLED_KEYS) ? nk : FILLED_KEYS;
		sel = int'($urandom_range(99));
		it = make_item(KIND_QUERY, 8'($urandom), 4'($urandom), $urandom, $urandom,
			1'($urandom), 31'($urandom));
		if (sel < 8) begin
			it.kind = KIND_DESC;
			if ($urandom_range(3) != 0) it.range_width = 31'($urandom_range(32'h0100_0000));
		end else if (sel < 18) begin
			it.kind = KIND_TIME;
			// The last filled key keeps its time, which bounds every walk.
			ki = int'($urandom_range(FILLED_KEYS - 2));
			it.key_index = 8'(ki);
			lo = (ki > 0) ? key_time_tbl[ki - 1] : 32'h0;
			hi = key_time_tbl[ki + 1];
			// Mostly keep the key times in order so the walk goes deep.
			if (hi >= lo && $urandom_range(99) < 85) it.time_value = $urandom_range(hi, lo);
		end else if (sel < 35) begin
			it.kind = KIND_VALUE;
			ki = int'($urandom_range(FILLED_KEYS - 1));
			it.key_index = 8'(ki);
			it.sample_value = pick_sample();
		end else begin
			lo = key_time_tbl[0];
			hi = key_time_tbl[top - 1];
			lo = (lo > 32'h0002_0000) ? lo - 32'h0002_0000 : 32'h0;
			if (nk <= FILLED_KEYS) begin
				hi = (hi < 32'hFFFD_FFFF) ? hi + 32'h0002_0000 : 32'hFFFF_FFFF;
				if ($urandom_range(99) < 15) begin
					lo = 32'h0;
					hi = 32'hFFFF_FFFF;
				end
			end
			if (hi >= lo) it.time_value = $urandom_range(hi, lo);
			else it.time_value = hi;
		end
		return it;
	endfunction

	typedef struct {
		in_item_t           item;
		bit                 typed_chk;
		logic signed [31:0] typed_value;
	} stim_row_t;

	stim_row_t directed_rows[$];

	task automatic add_row(logic [1:0] kind, logic [7:0] ki, logic [3:0] vi, logic [31:0] tv,
			logic [31:0] sv, logic circ, logic [30:0] span, bit chk = 0,
			logic [31:0] ev = '0);
		stim_row_t r;
		r.item = make_item(kind, ki, vi, tv, sv, circ, span);
		r.typed_chk = chk;
		r.typed_value = ev;
		directed_rows = {directed_rows, r};
	endtask

	// Result checker.
	always @(posedge clk) begin
		if (out_valid && out_ready) begin
			if (pending_values.size() == 0) begin
				$display("%0t: unexpected result var=%0d value=%h last=%b", $realtime,
					out_data.out_var, out_data.out_value, out_data.last);
				failed = 1;
			end else begin
				if (out_data.out_var !== pending_values[0].out_var) begin
					$display("%0t: out_var expected %0d actual %0d", $realtime,
						pending_values[0].out_var, out_data.out_var);
					failed = 1;
				end
				if (out_data.out_value !== pending_values[0].out_value) begin
					$display("%0t: out_value expected %h actual %h", $realtime,
						pending_values[0].out_value, out_data.out_value);
					failed = 1;
				end
				if (out_data.last !== pending_values[0].last) begin
					$display("%0t: last expected %b actual %b", $realtime,
						pending_values[0].last, out_data.last);
					failed = 1;
				end
				void'(pending_values.pop_front());
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) out_ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// Watchdog on cycles in which no channel moves a request.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("keyframe_interpolator_circular_unit_tb: FAIL");
			$finish;
		end
	end

	initial begin
		logic [31:0] t_acc;
		logic [15:0] phase_keys [NUM_PHASES];
		logic [15:0] phase_vars [NUM_PHASES];
		phase_keys = '{16'd0, 16'hFFFF, 16'd256, 16'd2, 16'd5, 16'd37};
		phase_vars = '{16'd0, 16'h001F, 16'd16, 16'd1, 16'd3, 16'd16};
		keys_reg = 9'd2;
		vars_reg = 5'd1;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Fill every entry that a query can reach so that none reads an unwritten slot.
		for (int v = 0; v < DEF_MAX_VARS; v++)
			send_request(make_item(KIND_DESC, 8'($urandom), 4'(v), $urandom, $urandom,
				1'($urandom), 31'($urandom_range(32'h0100_0000))));
		t_acc = 32'h0;
		for (int k = 0; k < FILLED_KEYS; k++) begin
			send_request(make_item(KIND_TIME, 8'(k), 4'($urandom), t_acc, $urandom,
				1'($urandom), 31'($urandom)));
			if ($urandom_range(9) != 0) t_acc += $urandom_range(32'h0003_FFFF);
		end
		for (int k = 0; k < FILLED_KEYS; k++)
			for (int v = 0; v < DEF_MAX_VARS; v++)
				send_request(make_item(KIND_VALUE, 8'(k), 4'(v), $urandom, pick_sample(),
					1'($urandom), 31'($urandom)));

		// Directed part at reset configuration: two keys, one variable.
		add_row(KIND_DESC, 8'd0, 4'd0, '0, '0, 1'b0, 31'h7FFF_FFFF);
		add_row(KIND_TIME, 8'd0, 4'd0, 32'h0001_0000, '0, 1'b0, '0);
		add_row(KIND_TIME, 8'd1, 4'd0, 32'h0003_0000, '0, 1'b0, '0);
		add_row(KIND_VALUE, 8'd0, 4'd0, '0, 32'h7FFF_FFFF, 1'b0, '0);
		add_row(KIND_VALUE, 8'd1, 4'd0, '0, 32'h8000_0000, 1'b0, '0);
		add_row(KIND_QUERY, 8'd0, 4'd0, 32'h0, '0, 1'b0, '0, 1, 32'h7FFF_FFFF);
		add_row(KIND_QUERY, 8'hFF, 4'hF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 31'h7FFF_FFFF,
			1, 32'h8000_0000);
		add_row(KIND_QUERY, 8'd0, 4'd0, 32'h0002_0000, '0, 1'b0, '0);
		add_row(KIND_QUERY, 8'd0, 4'd0, 32'h0001_8000, '0, 1'b0, '0);
		// Equal key times give the later value, decreasing ones the earlier.
		add_row(KIND_TIME, 8'd1, 4'd0, 32'h0001_0000, '0, 1'b0, '0);
		add_row(KIND_QUERY, 8'd0, 4'd0, 32'h0001_0000, '0, 1'b0, '0, 1, 32'h8000_0000);
		add_row(KIND_TIME, 8'd1, 4'd0, 32'h0, '0, 1'b0, '0);
		add_row(KIND_QUERY, 8'd0, 4'd0, 32'h0000_8000, '0, 1'b0, '0, 1, 32'h7FFF_FFFF);
		// Circular variable: a jump beyond four fifths of the range wraps.
		add_row(KIND_TIME, 8'd1, 4'd0, 32'h0003_0000, '0, 1'b0, '0);
		add_row(KIND_DESC, 8'd0, 4'd0, '0, '0, 1'b1, 31'h0004_0000);
		add_row(KIND_VALUE, 8'd0, 4'd0, '0, 32'h0001_0000, 1'b0, '0);
		add_row(KIND_VALUE, 8'd1, 4'd0, '0, 32'h0004_8000, 1'b0, '0);
		add_row(KIND_QUERY, 8'd0, 4'd0, 32'h0002_0000, '0, 1'b0, '0);
		add_row(KIND_VALUE, 8'd1, 4'd0, '0, 32'h0004_0000, 1'b0, '0);
		add_row(KIND_QUERY, 8'd0, 4'd0, 32'h0002_0000, '0, 1'b0, '0);
		add_row(KIND_DESC, 8'd0, 4'd0, '0, '0, 1'b1, 31'h0);
		add_row(KIND_VALUE, 8'd1, 4'd0, '0, 32'h0001_0000, 1'b0, '0);
		add_row(KIND_QUERY, 8'd0, 4'd0, 32'h0002_4000, '0, 1'b0, '0);
		foreach (directed_rows[i])
			send_request(directed_rows[i].item, directed_rows[i].typed_chk,
				directed_rows[i].typed_value);

		for (int p = 0; p < NUM_PHASES; p++) begin
			go_idle();
			write_reg(REG_KEYS_IN_USE, phase_keys[p]);
			write_reg(REG_VARS_IN_USE, phase_vars[p]);
			if (p < 2) begin
				send_idle_pct = 31;
				recv_idle_pct = 59;
			end else if (p < 4) begin
				send_idle_pct = 59;
				recv_idle_pct = 31;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				// Hold the sender off once until the block has drained.
				if (p == 3 && n == PHASE_ITEMS / 2) begin
					in_valid <= 1'b0;
					@(posedge clk);
					while (pending_values.size() != 0) @(posedge clk);
				end
				send_request(random_request());
			end
		end

		go_idle();
		if (!failed) begin
			$display("keyframe_interpolator_circular_unit_tb: PASS");
		end else begin
			$display("keyframe_interpolator_circular_unit_tb: FAIL");
		end
		$finish;
	end

endmodule
